FILE: src/sqltok_pkg.sv
// Shared types, widths and character classes for the SQL token scanner.
// Depends on nothing; used by sql_lexer_token_scanner_unit.

package sqltok_pkg;

  localparam int LINE_BITS   = 20;
  localparam int COLUMN_BITS = 16;
  localparam int LENGTH_BITS = 16;

  // Token class codes carried in the result tuser.
  localparam logic [2:0] CLS_WORD     = 3'd0;
  localparam logic [2:0] CLS_NUMBER   = 3'd1;
  localparam logic [2:0] CLS_STRING   = 3'd2;
  localparam logic [2:0] CLS_COMMENT  = 3'd3;
  localparam logic [2:0] CLS_OPERATOR = 3'd4;
  localparam logic [2:0] CLS_DELIM    = 3'd5;

  // Character constants.
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_LOW_E = 8'h65;
  localparam logic [7:0] CH_UP_E  = 8'h45;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_DQ    = 8'h22;

  // One result record.
  typedef struct packed {
    logic [2:0]             cls;
    logic [LINE_BITS-1:0]   line;
    logic [COLUMN_BITS-1:0] column;
    logic [LENGTH_BITS-1:0] length;
    logic                   last;
  } tok_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || c == CH_UNDER;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  // Bytes that open a possible two-character operator.
  function automatic logic is_op_start(input logic [7:0] c);
    return c == 8'h3C || c == 8'h3E || c == 8'h21 || c == 8'h3D ||
           c == 8'h7C || c == 8'h26 || c == 8'h3A;
  endfunction

  function automatic logic is_delim(input logic [7:0] c);
    return c == 8'h28 || c == 8'h29 || c == 8'h5B || c == 8'h5D ||
           c == 8'h7B || c == 8'h7D || c == 8'h2C || c == 8'h3B;
  endfunction

  // True when held byte h and byte b form one of the two-character operators.
  function automatic logic is_pair(input logic [7:0] h, input logic [7:0] b);
    return (h == 8'h3C && (b == 8'h3D || b == 8'h3E || b == 8'h3C)) ||
           (h == 8'h3E && (b == 8'h3D || b == 8'h3E)) ||
           (h == 8'h21 && b == 8'h3D) || (h == 8'h3D && b == 8'h3D) ||
           (h == 8'h7C && b == 8'h7C) || (h == 8'h26 && b == 8'h26) ||
           (h == 8'h3A && b == 8'h3A);
  endfunction

endpackage

FILE: src/sql_lexer_token_scanner_unit.sv
// SQL token scanner: byte-wide lexer with a three-entry result queue.
// A token's record is registered into the queue when the byte that closes it is taken.
// Throughput: one byte per cycle while the queue holds at most one record; a byte
// yielding two records is taken whole; queue drains one a cycle with m_tready high.
// Reset (rst, synchronous): lexer idle, line and column at one, queue empty.
// Depends on sqltok_pkg.

module sql_lexer_token_scanner_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,   // end_of_input
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // [19:0] token_line, [35:20] token_column,
                                 // [51:36] token_length, [55:52] zero
  output logic [2:0]  m_tuser,   // [2:0] token_class
  output logic        m_tlast    // last_of_run
);

  localparam int LB = sqltok_pkg::LINE_BITS;
  localparam int CB = sqltok_pkg::COLUMN_BITS;
  localparam int NB = sqltok_pkg::LENGTH_BITS;

  typedef enum logic [3:0] {
    M_IDLE, M_WORD, M_NUM, M_NUMSIGN, M_STR, M_STRQ,
    M_LCOM, M_SLASH, M_BLOCK, M_BSTAR, M_DASH, M_OPER
  } mode_t;

  function automatic logic [2:0] mode_class(input mode_t m);
    case (m)
      M_WORD:                   return sqltok_pkg::CLS_WORD;
      M_NUM, M_NUMSIGN:         return sqltok_pkg::CLS_NUMBER;
      M_STR, M_STRQ:            return sqltok_pkg::CLS_STRING;
      M_LCOM, M_BLOCK, M_BSTAR: return sqltok_pkg::CLS_COMMENT;
      default:                  return sqltok_pkg::CLS_OPERATOR;
    endcase
  endfunction

  // Lexer state.
  mode_t         mode;
  logic [LB-1:0] line_count, first_line;
  logic [CB-1:0] column_count, first_column;
  logic [NB-1:0] length_count;
  logic [7:0]    held_byte, open_quote;
  logic          seen_dot, seen_exponent;

  mode_t         mode_next;
  logic [LB-1:0] line_count_next, first_line_next;
  logic [CB-1:0] column_count_next, first_column_next;
  logic [NB-1:0] length_count_next;
  logic [7:0]    held_byte_next, open_quote_next;
  logic          seen_dot_next, seen_exponent_next;

  // Result queue, head in slot 0.
  sqltok_pkg::tok_t q [3];
  sqltok_pkg::tok_t q_next [3];
  logic [1:0]       cnt, cnt_next;

  sqltok_pkg::tok_t res [2];
  logic [1:0]       nres;

  logic [7:0] b;
  logic       eoi, acc, pop;
  logic       disp, num_path;

  assign b        = s_tdata;
  assign eoi      = s_tlast;
  assign s_tready = (cnt <= 2'd1);
  assign acc      = s_tvalid && s_tready;
  assign m_tvalid = (cnt != 2'd0);
  assign pop      = m_tvalid && m_tready;

  assign m_tdata = {4'd0, q[0].length, q[0].column, q[0].line};
  assign m_tuser = q[0].cls;
  assign m_tlast = q[0].last;

  // Per-byte mode transition and result formation.
  always_comb begin
    mode_next          = mode;
    line_count_next    = line_count;
    column_count_next  = column_count;
    first_line_next    = first_line;
    first_column_next  = first_column;
    length_count_next  = length_count;
    held_byte_next     = held_byte;
    open_quote_next    = open_quote;
    seen_dot_next      = seen_dot;
    seen_exponent_next = seen_exponent;
    disp               = 1'b0;
    num_path           = 1'b0;
    nres               = 2'd0;
    res[0]             = '0;
    res[1]             = '0;

    unique case (mode)
      M_WORD: begin
        if (sqltok_pkg::is_word(b)) begin
          if (length_count_next != '1) length_count_next = length_count_next + 1'b1;
        end else begin
          res[nres[0]] = '{sqltok_pkg::CLS_WORD, first_line_next, first_column_next,
                           length_count_next, 1'b0};
          nres      = nres + 2'd1;
          mode_next = M_IDLE;
          disp      = 1'b1;
        end
      end
      M_NUM: num_path = 1'b1;
      M_NUMSIGN: begin
        if (b == sqltok_pkg::CH_PLUS || b == sqltok_pkg::CH_DASH) begin
          if (length_count_next != '1) length_count_next = length_count_next + 1'b1;
          mode_next = M_NUM;
        end else begin
          num_path = 1'b1;
        end
      end
      M_STR: begin
        if (length_count_next != '1) length_count_next = length_count_next + 1'b1;
        if (b == open_quote) mode_next = M_STRQ;
      end
      M_STRQ: begin
        if (b == open_quote) begin
          if (length_count_next != '1) length_count_next = length_count_next + 1'b1;
          mode_next = M_STR;
        end else begin
          res[nres[0]] = '{sqltok_pkg::CLS_STRING, first_line_next, first_column_next,
                           length_count_next, 1'b0};
          nres      = nres + 2'd1;
          mode_next = M_IDLE;
          disp      = 1'b1;
        end
      end
      M_DASH: begin
        if (b == sqltok_pkg::CH_DASH) begin
          if (length_count_next != '1) length_count_next = length_count_next + 1'b1;
          mode_next = M_LCOM;
        end else begin
          res[nres[0]] = '{sqltok_pkg::CLS_OPERATOR, first_line_next, first_column_next,
                           length_count_next, 1'b0};
          nres      = nres + 2'd1;
          mode_next = M_IDLE;
          disp      = 1'b1;
        end
      end
      M_LCOM: begin
        if (length_count_next != '1) length_count_next = length_count_next + 1'b1;
        if (b == sqltok_pkg::CH_NL) begin
          res[nres[0]] = '{sqltok_pkg::CLS_COMMENT, first_line_next, first_column_next,
                           length_count_next, 1'b0};
          nres      = nres + 2'd1;
          mode_next = M_IDLE;
        end
      end
      M_SLASH: begin
        if (b == sqltok_pkg::CH_STAR) begin
          if (length_count_next != '1) length_count_next = length_count_next + 1'b1;
          mode_next = M_BLOCK;
        end else begin
          res[nres[0]] = '{sqltok_pkg::CLS_OPERATOR, first_line_next, first_column_next,
                           length_count_next, 1'b0};
          nres      = nres + 2'd1;
          mode_next = M_IDLE;
          disp      = 1'b1;
        end
      end
      M_BLOCK: begin
        if (length_count_next != '1) length_count_next = length_count_next + 1'b1;
        if (b == sqltok_pkg::CH_STAR) mode_next = M_BSTAR;
      end
      M_BSTAR: begin
        if (length_count_next != '1) length_count_next = length_count_next + 1'b1;
        if (b == sqltok_pkg::CH_SLASH) begin
          res[nres[0]] = '{sqltok_pkg::CLS_COMMENT, first_line_next, first_column_next,
                           length_count_next, 1'b0};
          nres      = nres + 2'd1;
          mode_next = M_IDLE;
        end else if (b != sqltok_pkg::CH_STAR) begin
          mode_next = M_BLOCK;
        end
      end
      M_OPER: begin
        // A pair closes the operator with this byte; otherwise it stands alone.
        if (sqltok_pkg::is_pair(held_byte, b)) begin
          if (length_count_next != '1) length_count_next = length_count_next + 1'b1;
        end else begin
          disp = 1'b1;
        end
        res[nres[0]] = '{sqltok_pkg::CLS_OPERATOR, first_line_next, first_column_next,
                         length_count_next, 1'b0};
        nres      = nres + 2'd1;
        mode_next = M_IDLE;
      end
      default: begin
        mode_next = M_IDLE;
        disp      = 1'b1;
      end
    endcase

    // Number continuation: digits, one dot before any exponent, one exponent.
    if (num_path) begin
      mode_next = M_NUM;
      if (sqltok_pkg::is_digit(b)) begin
        if (length_count_next != '1) length_count_next = length_count_next + 1'b1;
      end else if (b == sqltok_pkg::CH_DOT && !seen_dot && !seen_exponent) begin
        seen_dot_next = 1'b1;
        if (length_count_next != '1) length_count_next = length_count_next + 1'b1;
      end else if ((b == sqltok_pkg::CH_LOW_E || b == sqltok_pkg::CH_UP_E) &&
                   !seen_exponent) begin
        seen_exponent_next = 1'b1;
        if (length_count_next != '1) length_count_next = length_count_next + 1'b1;
        mode_next = M_NUMSIGN;
      end else begin
        res[nres[0]] = '{sqltok_pkg::CLS_NUMBER, first_line_next, first_column_next,
                         length_count_next, 1'b0};
        nres      = nres + 2'd1;
        mode_next = M_IDLE;
        disp      = 1'b1;
      end
    end

    // Start of a new token, or a one-byte token, in idle mode or on a byte that ends one.
    if (disp && !sqltok_pkg::is_space(b)) begin
      if (sqltok_pkg::is_delim(b) || !(sqltok_pkg::is_alpha(b) ||
          b == sqltok_pkg::CH_UNDER || sqltok_pkg::is_digit(b) ||
          b == sqltok_pkg::CH_SQ || b == sqltok_pkg::CH_DQ ||
          b == sqltok_pkg::CH_DASH || b == sqltok_pkg::CH_SLASH ||
          sqltok_pkg::is_op_start(b))) begin
        res[nres[0]] = '{sqltok_pkg::is_delim(b) ? sqltok_pkg::CLS_DELIM
                                                 : sqltok_pkg::CLS_OPERATOR,
                         line_count, column_count, NB'(1), 1'b0};
        nres = nres + 2'd1;
      end else begin
        first_line_next   = line_count;
        first_column_next = column_count;
        length_count_next = NB'(1);
        if (sqltok_pkg::is_alpha(b) || b == sqltok_pkg::CH_UNDER) begin
          mode_next = M_WORD;
        end else if (sqltok_pkg::is_digit(b)) begin
          mode_next          = M_NUM;
          seen_dot_next      = 1'b0;
          seen_exponent_next = 1'b0;
        end else if (b == sqltok_pkg::CH_SQ || b == sqltok_pkg::CH_DQ) begin
          mode_next       = M_STR;
          open_quote_next = b;
        end else if (b == sqltok_pkg::CH_DASH) begin
          mode_next      = M_DASH;
          held_byte_next = b;
        end else if (b == sqltok_pkg::CH_SLASH) begin
          mode_next      = M_SLASH;
          held_byte_next = b;
        end else begin
          mode_next      = M_OPER;
          held_byte_next = b;
        end
      end
    end

    // Position counters follow every byte and saturate.
    if (b == sqltok_pkg::CH_NL) begin
      if (line_count != '1) line_count_next = line_count + 1'b1;
      column_count_next = CB'(1);
    end else if (column_count != '1) begin
      column_count_next = column_count + 1'b1;
    end

    // End of input flushes any open token and returns the lexer to the reset state.
    if (eoi) begin
      if (mode_next != M_IDLE) begin
        res[nres[0]] = '{mode_class(mode_next), first_line_next, first_column_next,
                         length_count_next, 1'b0};
        nres = nres + 2'd1;
      end
      mode_next          = M_IDLE;
      line_count_next    = LB'(1);
      column_count_next  = CB'(1);
      first_line_next    = LB'(1);
      first_column_next  = CB'(1);
      length_count_next  = '0;
      held_byte_next     = '0;
      open_quote_next    = '0;
      seen_dot_next      = 1'b0;
      seen_exponent_next = 1'b0;
    end

    // Mark the final record of this byte.
    if (nres == 2'd1) res[0].last = 1'b1;
    if (nres == 2'd2) res[1].last = 1'b1;
  end

  // Queue update: shift out the head on a pop, then append this byte's records.
  logic [1:0] base;
  always_comb begin
    base = cnt - {1'b0, pop};
    for (int i = 0; i < 3; i++) q_next[i] = q[i];
    if (pop) begin
      q_next[0] = q[1];
      q_next[1] = q[2];
    end
    for (int i = 0; i < 3; i++) begin
      if (acc && nres != 2'd0 && base == 2'(i)) q_next[i] = res[0];
      if (acc && nres == 2'd2 && base + 2'd1 == 2'(i)) q_next[i] = res[1];
    end
    cnt_next = base + (acc ? nres : 2'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= M_IDLE;
      line_count    <= LB'(1);
      column_count  <= CB'(1);
      first_line    <= LB'(1);
      first_column  <= CB'(1);
      length_count  <= '0;
      held_byte     <= '0;
      open_quote    <= '0;
      seen_dot      <= 1'b0;
      seen_exponent <= 1'b0;
      cnt           <= 2'd0;
    end else begin
      if (acc) begin
        mode          <= mode_next;
        line_count    <= line_count_next;
        column_count  <= column_count_next;
        first_line    <= first_line_next;
        first_column  <= first_column_next;
        length_count  <= length_count_next;
        held_byte     <= held_byte_next;
        open_quote    <= open_quote_next;
        seen_dot      <= seen_dot_next;
        seen_exponent <= seen_exponent_next;
      end
      cnt <= cnt_next;
    end
  end

  // Queue payload needs no reset.
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) q[i] <= q_next[i];
  end

  // The input is never ready while the queue holds three records.
  assert property (@(posedge clk) disable iff (rst) cnt != 2'd3 || !s_tready)
    else $error("queue full but input ready");

  // After the last byte of a stream the lexer is back at line one, idle.
  assert property (@(posedge clk) disable iff (rst)
    (acc && eoi) |=> (mode == M_IDLE && line_count == LB'(1) && column_count == CB'(1)))
    else $error("state not cleared after end of input");

  // Every delivered record has a nonzero length and a line of at least one.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (q[0].length != '0 && q[0].line != '0))
    else $error("record with zero length or line");

  // A byte never yields more than two records.
  assert property (@(posedge clk) disable iff (rst) acc |-> nres != 2'd3)
    else $error("more than two records from one byte");

endmodule
